/* hdl/saa_pkg.sv */
// Shared types, codes and sizing for the subnet address allocator.
// No dependencies; the allocator, the checker and the bench import this package.
`timescale 1ns / 1ps
`default_nettype none

package saa_pkg;

   // Widest host field the tree covers; the tree has 2^(HOST_BITS+1) nodes.
   localparam int HOST_BITS  = 8;
   localparam int HOST_W     = $clog2(HOST_BITS + 1);
   localparam int NODE_W     = HOST_BITS + 1;
   localparam int TREE_NODES = 2 ** NODE_W;
   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 2;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_RESERVED  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NETWORK = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX  = CSR_IDX_W'(1);

   localparam logic [4:0] PREFIX_RESET = 5'd24;

   typedef struct packed {
      logic [1:0]        command;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  result_address;
      logic [1:0]         status;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

   // Host bits in use: 32 minus the prefix, held between 2 and HOST_BITS.
   function automatic logic [HOST_W-1:0] host_width(input logic [4:0] prefix);
      logic [5:0] w;
      w = 6'd32 - {1'b0, prefix};
      if (w > 6'(HOST_BITS)) begin
         return HOST_W'(HOST_BITS);
      end else if (w < 6'd2) begin
         return HOST_W'(2);
      end else begin
         return HOST_W'(w);
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/saa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the full-flag tree of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module saa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/subnet_address_allocator.sv */
// Subnet address allocator: binary tree of full flags walked by one sequencer.
// Depends on saa_pkg and saa_ram.
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_ready      req_type (command, address)
//   rsp_      out        rsp_valid / rsp_ready      rsp_type (address, status, count)
//   csr_      in         csr_valid / csr_ready      csr_index, csr_data
//
// One item at a time; the flag RAM port pair sets the pace, one tree level a cycle.
// Allocate walks down from the root to a leaf and back up, free walks up from its leaf.
// Reset, clear and a write to the network or prefix register start a clearing pass.
// The result sits in an output register, so a stalled rsp_ready only holds the
// sequencer in its final state; req_ready returns once that register is loaded.
`timescale 1ns / 1ps
`default_nettype none

module subnet_address_allocator
   import saa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_ROOT  = 7'b0000100,
      ST_DESC  = 7'b0001000,
      ST_FREE  = 7'b0010000,
      ST_UP    = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   network_ff, network_in;
   logic [4:0]          prefix_ff, prefix_in;
   logic [NODE_W-1:0]   cnt_ff, cnt_in;
   logic                reply_ff, reply_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [HOST_W-1:0]   lvl_ff, lvl_in;
   logic                val_ff, val_in;
   logic [HOST_BITS-1:0] free_ff, free_in;
   logic [ADDR_W-1:0]   result_ff, result_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                ram_we;
   logic [NODE_W-1:0]   ram_waddr;
   logic                ram_wdata;
   logic [NODE_W-1:0]   ram_raddr;
   logic                ram_rdata;

   logic [HOST_W-1:0]    h_w;
   logic [HOST_BITS-1:0] hmask;
   logic [ADDR_W-1:0]    base;
   logic [NODE_W-1:0]    leaf_base;
   logic [NODE_W-1:0]    top_node;
   logic [NODE_W-1:0]    inner_node;
   logic [HOST_BITS-1:0] req_idx;
   logic                 req_reserved;
   logic                 clear_flag;
   logic [NODE_W-1:0]    desc_node;
   logic [NODE_W-1:0]    parent;
   logic                 parent_val;
   logic                 rsp_load;
   logic                 req_fire;
   logic                 csr_fire;

   saa_ram #(
      .WIDTH (1),
      .DEPTH (TREE_NODES)
   ) u_flags (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign h_w        = host_width(prefix_ff);
   assign hmask      = HOST_BITS'((HOST_BITS'(1) << h_w) - HOST_BITS'(1));
   assign base       = network_ff & ~ADDR_W'(hmask);
   assign leaf_base  = NODE_W'(1) << h_w;
   assign top_node   = NODE_W'((leaf_base << 1) - NODE_W'(1));
   assign inner_node = NODE_W'(leaf_base - NODE_W'(1));

   assign req_idx      = req_data.address[HOST_BITS-1:0] & hmask;
   assign req_reserved = (req_idx == '0) || (req_idx == hmask)
                      || (req_idx == HOST_BITS'(hmask - HOST_BITS'(1)));

   // Reserved leaves: network, server and broadcast; the last two share a full parent.
   assign clear_flag = (cnt_ff == leaf_base) || (cnt_ff == top_node)
                    || (cnt_ff == NODE_W'(top_node - NODE_W'(1)))
                    || (cnt_ff == inner_node);

   assign desc_node  = node_ff | NODE_W'(ram_rdata);
   assign parent     = node_ff >> 1;
   assign parent_val = val_ff & ram_rdata;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      network_in = network_ff;
      prefix_in  = prefix_ff;
      cnt_in     = cnt_ff;
      reply_in   = reply_ff;
      node_in    = node_ff;
      lvl_in     = lvl_ff;
      val_in     = val_ff;
      free_in    = free_ff;
      result_in  = result_ff;
      status_in  = status_ff;
      ram_we     = 1'b0;
      ram_waddr  = cnt_ff;
      ram_wdata  = 1'b0;
      ram_raddr  = node_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               if (csr_index == CSR_NETWORK) begin
                  network_in = csr_data;
                  cnt_in     = '0;
                  reply_in   = 1'b0;
                  state_in   = ST_CLEAR;
               end else if (csr_index == CSR_PREFIX) begin
                  prefix_in  = csr_data[4:0];
                  cnt_in     = '0;
                  reply_in   = 1'b0;
                  state_in   = ST_CLEAR;
               end
            end else if (req_fire) begin
               result_in = '0;
               status_in = STATUS_DONE;
               case (req_data.command)
                  CMD_ALLOC: begin
                     ram_raddr = NODE_W'(1);
                     state_in  = ST_ROOT;
                  end
                  CMD_FREE: begin
                     if (req_reserved) begin
                        status_in = STATUS_RESERVED;
                        state_in  = ST_RESP;
                     end else begin
                        node_in   = leaf_base | NODE_W'(req_idx);
                        ram_raddr = leaf_base | NODE_W'(req_idx);
                        state_in  = ST_FREE;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     reply_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = clear_flag;
            cnt_in    = NODE_W'(cnt_ff + NODE_W'(1));
            if (cnt_ff == '1) begin
               free_in  = HOST_BITS'((HOST_BITS'(1) << h_w) - HOST_BITS'(3));
               state_in = reply_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (ram_rdata) begin
               status_in = STATUS_EXHAUSTED;
               state_in  = ST_RESP;
            end else begin
               node_in   = NODE_W'(2);
               ram_raddr = NODE_W'(2);
               lvl_in    = HOST_W'(1);
               state_in  = ST_DESC;
            end
         end
         ST_DESC: begin
            // node_ff is a left child; step right when it is full
            if (lvl_ff == h_w) begin
               ram_we    = 1'b1;
               ram_waddr = desc_node;
               ram_wdata = 1'b1;
               ram_raddr = desc_node ^ NODE_W'(1);
               node_in   = desc_node;
               val_in    = 1'b1;
               free_in   = HOST_BITS'(free_ff - HOST_BITS'(1));
               result_in = base | ADDR_W'(desc_node[HOST_BITS-1:0] & hmask);
               state_in  = ST_UP;
            end else begin
               node_in   = NODE_W'(desc_node << 1);
               ram_raddr = NODE_W'(desc_node << 1);
               lvl_in    = HOST_W'(lvl_ff + HOST_W'(1));
            end
         end
         ST_FREE: begin
            if (ram_rdata) begin
               ram_we    = 1'b1;
               ram_waddr = node_ff;
               ram_wdata = 1'b0;
               ram_raddr = node_ff ^ NODE_W'(1);
               val_in    = 1'b0;
               free_in   = HOST_BITS'(free_ff + HOST_BITS'(1));
               state_in  = ST_UP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UP: begin
            // ram_rdata holds the sibling of node_ff; write the parent, fetch its sibling
            ram_we    = 1'b1;
            ram_waddr = parent;
            ram_wdata = parent_val;
            ram_raddr = parent ^ NODE_W'(1);
            node_in   = parent;
            val_in    = parent_val;
            if (parent == NODE_W'(1)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.result_address = result_ff;
         rsp_data_in.status         = status_ff;
         rsp_data_in.free_count     = COUNT_W'(free_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         network_ff   <= '0;
         prefix_ff    <= PREFIX_RESET;
         cnt_ff       <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         network_ff   <= network_in;
         prefix_ff    <= prefix_in;
         cnt_ff       <= cnt_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      lvl_ff      <= lvl_in;
      val_ff      <= val_in;
      free_ff     <= free_in;
      result_ff   <= result_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/saa_checker.sv */
// Port-level checks for the subnet address allocator, bound to the top level.
// Depends on saa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module saa_checker
   import saa_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire req_type              req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire rsp_type              rsp_data,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [ADDR_W-1:0]    csr_data
);

   // the clearing pass keeps items out right after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one item at a time: an accepted item closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped or changed while stalled");

   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_DONE) |-> (rsp_data.result_address == '0))
      else $error("address returned with a failing status");

   a_empty_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_EXHAUSTED) |-> (rsp_data.free_count == '0))
      else $error("pool reported exhausted with free hosts left");

endmodule

bind subnet_address_allocator saa_checker u_saa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for subnet_address_allocator: random and directed traffic with
// a host-pool scoreboard that predicts every reply. Depends on saa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top
   import saa_pkg::*;
();

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int WATCHDOG_LIMIT        = 5000;
   localparam int SETTLE_CYCLES         = 24;
   localparam int PRESSURE_CYCLES       = 400;
   localparam int PHASES                = 8;
   localparam int PHASE_PREFIX [PHASES] = '{30, 31, 29, 28, 24, 0, 27, 26};
   localparam int PHASE_ITEMS  [PHASES] = '{120, 80, 120, 150, 330, 150, 150, 100};
   localparam int PHASE_ALLOC  [PHASES] = '{55, 55, 55, 60, 90, 50, 60, 55};
   localparam int PHASE_CLEAR  [PHASES] = '{3, 3, 3, 2, 0, 3, 2, 2};

   class host_pool_scoreboard;
      bit          full_flag [TREE_NODES];
      logic [31:0] network;
      logic [4:0]  prefix;
      int unsigned free_hosts;
      rsp_type     pending_replies [$];
      int          errors;

      function new();
         network = '0;
         prefix  = PREFIX_RESET;
         errors  = 0;
         refill_pool();
      endfunction

      function int host_bits();
         int h;
         h = 32 - int'(prefix);
         if (h > HOST_BITS) begin
            h = HOST_BITS;
         end
         if (h < 2) begin
            h = 2;
         end
         return h;
      endfunction

      function bit is_reserved(int h, int idx);
         int mask;
         mask = (1 << h) - 1;
         return idx == 0 || idx == mask || idx == mask - 1;
      endfunction

      // Set or clear one leaf, then recompute every ancestor.
      function void mark_leaf(int h, int idx, bit val);
         int node;
         node = (1 << h) | (idx & ((1 << h) - 1));
         full_flag[node] = val;
         while (node > 1) begin
            node = node >> 1;
            full_flag[node] = full_flag[2 * node] & full_flag[2 * node + 1];
         end
      endfunction

      function void refill_pool();
         int h;
         h = host_bits();
         foreach (full_flag[i]) begin
            full_flag[i] = 1'b0;
         end
         mark_leaf(h, 0, 1'b1);
         mark_leaf(h, (1 << h) - 1, 1'b1);
         mark_leaf(h, (1 << h) - 2, 1'b1);
         free_hosts = (1 << h) - 3;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
         case (index)
            CSR_NETWORK: network = data;
            CSR_PREFIX:  prefix = data[4:0];
            default:     return;
         endcase
         refill_pool();
      endfunction

      function void note_request(req_type item);
         int      h, mask, node, idx;
         rsp_type reply;
         h     = host_bits();
         mask  = (1 << h) - 1;
         reply = '0;
         reply.status = STATUS_DONE;
         case (item.command)
            CMD_ALLOC: begin
               if (full_flag[1]) begin
                  reply.status = STATUS_EXHAUSTED;
               end else begin
                  // Descend toward the lowest free leaf, left child first.
                  node = 1;
                  for (int lvl = 0; lvl < h; lvl++) begin
                     node = 2 * node;
                     if (full_flag[node]) begin
                        node++;
                     end
                  end
                  idx = node - (1 << h);
                  mark_leaf(h, idx, 1'b1);
                  free_hosts--;
                  reply.result_address = (network & ~32'(mask)) | 32'(idx);
               end
            end
            CMD_FREE: begin
               idx = int'(item.address & 32'(mask));
               if (is_reserved(h, idx)) begin
                  reply.status = STATUS_RESERVED;
               end else if (full_flag[(1 << h) | idx]) begin
                  mark_leaf(h, idx, 1'b0);
                  free_hosts++;
               end
            end
            CMD_CLEAR: refill_pool();
            default: ;
         endcase
         reply.free_count = COUNT_W'(free_hosts);
         pending_replies.push_back(reply);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) begin
            $display("mismatch at %0t: %s", $realtime, msg);
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply %h with no request waiting", got));
         end else begin
            want = pending_replies.pop_front();
            if (got.result_address !== want.result_address) begin
               report_mismatch($sformatf("result_address got %h want %h",
                                         got.result_address, want.result_address));
            end
            if (got.status !== want.status) begin
               report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            end
            if (got.free_count !== want.free_count) begin
               report_mismatch($sformatf("free_count got %0d want %0d",
                                         got.free_count, want.free_count));
            end
         end
      endtask

      // Find an allocated, non-reserved host at or after start, wrapping around.
      function int pick_used(int start);
         int h, size, idx;
         h    = host_bits();
         size = 1 << h;
         for (int k = 0; k < size; k++) begin
            idx = (start + k) % size;
            if (full_flag[size + idx] && !is_reserved(h, idx)) begin
               return idx;
            end
         end
         return start;
      endfunction
   endclass

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [ADDR_W-1:0]    csr_data    = '0;

   host_pool_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;
   int quiet_cycles  = 0;

   subnet_address_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: long hold-off when requested, otherwise random stalls.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor every handshake and watch for a hung block.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_register(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function void set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 55; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 55; end
         default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
      endcase
   endfunction

   task automatic send_item(input logic [1:0] command, input logic [31:0] address);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: command, address: address};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every outstanding reply, then let the sequencer settle.
   task automatic drain_replies();
      @(posedge clock);
      req_valid <= 1'b0;
      while (sb.pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int count, int alloc_pct, int clear_pct, bit squeeze);
      int          roll, pick, h, mask, idx;
      logic [31:0] base, addr;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == 10) begin
            hold_cycles = PRESSURE_CYCLES;
         end
         roll = $urandom_range(99);
         h    = sb.host_bits();
         mask = (1 << h) - 1;
         base = sb.network & ~32'(mask);
         if (roll < alloc_pct) begin
            send_item(CMD_ALLOC, $urandom);
         end else if (roll < alloc_pct + clear_pct) begin
            send_item(CMD_CLEAR, $urandom);
         end else if (roll < alloc_pct + clear_pct + 3) begin
            send_item(CMD_UNUSED, $urandom);
         end else begin
            pick = $urandom_range(3);
            if (pick == 0) begin
               addr = $urandom;
            end else begin
               // Release a host in use; sometimes with foreign network bits.
               idx  = sb.pick_used($urandom_range(mask));
               addr = (pick == 1) ? (($urandom & ~32'(mask)) | 32'(idx)) : (base | 32'(idx));
            end
            send_item(CMD_FREE, addr);
         end
      end
   endtask

   initial begin
      logic [31:0] net;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, 8 host bits, base 0.
      set_idling(3);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_FREE,  32'h0000_0001);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_FREE,  32'h0000_0000);
      send_item(CMD_FREE,  32'hFFFF_FFFF);
      send_item(CMD_FREE,  32'h0000_00FE);
      send_item(CMD_FREE,  32'h0000_0064);
      send_item(CMD_FREE,  32'hFFFF_FF02);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF);
      send_item(CMD_CLEAR, 32'h0000_0000);
      send_item(CMD_ALLOC, 32'h5A5A_A5A5);
      send_item(CMD_ALLOC, 32'hA5A5_5A5A);
      drain_replies();

      // Directed: prefix 31 clamps to two host bits, one usable host.
      write_csr(CSR_NETWORK, 32'hFFFF_FFFF);
      write_csr(CSR_PREFIX, {27'($urandom), 5'd31});
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_FREE,  32'hFFFF_FFFD);
      send_item(CMD_FREE,  32'hFFFF_FFFD);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_FREE,  32'h0000_0001);
      drain_replies();

      for (int p = 0; p < PHASES; p++) begin
         set_idling(p % 4);
         case (p)
            1:       net = 32'hFFFF_FFFF;
            3:       net = 32'h0000_0000;
            default: net = $urandom;
         endcase
         write_csr(CSR_NETWORK, net);
         write_csr(CSR_PREFIX, {27'($urandom), 5'(PHASE_PREFIX[p])});
         run_phase(PHASE_ITEMS[p], PHASE_ALLOC[p], PHASE_CLEAR[p], p == 4);
         drain_replies();
      end

      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/saa_pkg.sv
hdl/saa_ram.sv
hdl/subnet_address_allocator.sv
hdl/saa_checker.sv
tb/sv/tb_top.sv
